// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Plain property, clocked on clk_i, off during reset.
`define BBE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Same-cycle implication.
`define BBE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define BBE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/core/bbe_pkg.sv =====
// Package: sizes, codes, structs and helpers of the B-spline basis evaluator.
`default_nettype none
package bbe_pkg;
  localparam int MAX_CP     = 32;
  localparam int MAX_DEG    = 7;
  localparam int KNOT_DEPTH = 40;

  localparam int CP_W   = $clog2(MAX_CP);
  localparam int CNT_W  = 6;
  localparam int DEG_W  = 3;
  localparam int DD_W   = $clog2(MAX_DEG + 1);
  localparam int KA_W   = $clog2(KNOT_DEPTH);
  localparam int KX_W   = CP_W + DD_W + 1;
  localparam int GP_W   = 33 + KX_W + 1;
  localparam int NW     = 56;
  localparam int DW     = 35;
  localparam int QW     = NW + 1;
  localparam int CNTD_W = $clog2(NW);

  localparam logic [16:0] Q_ONE = 17'h10000;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_GEN  = 2'd1;
  localparam logic [1:0] CMD_EVAL = 2'd2;

  localparam logic [2:0] REG_DEGREE = 3'd0;
  localparam logic [2:0] REG_COUNT  = 3'd1;
  localparam logic [2:0] REG_MODE   = 3'd2;
  localparam logic [2:0] REG_RMIN   = 3'd3;
  localparam logic [2:0] REG_RMAX   = 3'd4;

  typedef struct packed {
    logic                 start;
    logic signed [NW-1:0] num;
    logic [DW-1:0]        den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [QW-1:0] quo;
  } div_rsp_t;

  function automatic logic [16:0] clampq(input logic signed [QW:0] v);
    logic [16:0] r;
    if (v[QW]) r = '0;
    else if ((|v[QW-1:17]) || (v[16] && (|v[15:0]))) r = Q_ONE;
    else r = v[16:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [QW:0] v);
    logic signed [31:0] r;
    if (!v[QW] && (|v[QW-1:31])) r = 32'sh7FFFFFFF;
    else if (v[QW] && !(&v[QW-1:31])) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/bbe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bbe_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 40,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/core/bbe_div.sv =====
// Iterative signed floor divider, one quotient bit per cycle.
`default_nettype none
module bbe_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bbe_pkg::div_req_t req_i,
  output bbe_pkg::div_rsp_t      rsp_o
);
  logic                        busy_q, fin_q, done_q, neg_q;
  logic [bbe_pkg::CNTD_W-1:0]  cnt_q;
  logic [bbe_pkg::DW-1:0]      rem_q, den_q;
  logic [bbe_pkg::NW-1:0]      sh_q;
  logic signed [bbe_pkg::QW-1:0] quo_q;
  logic [bbe_pkg::DW:0]        rem_sh, rem_nx;
  logic                        ge;

  always_comb begin
    rem_sh = {rem_q, sh_q[bbe_pkg::NW-1]};
    ge     = rem_sh >= {1'b0, den_q};
    rem_nx = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q && !busy_q && !req_i.start;
      if (req_i.start) begin
        busy_q <= 1'b1;
        fin_q  <= 1'b0;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == bbe_pkg::CNTD_W'(bbe_pkg::NW - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        fin_q  <= 1'b0;
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.num[bbe_pkg::NW-1];
      sh_q  <= req_i.num[bbe_pkg::NW-1] ? (bbe_pkg::NW'(0) - req_i.num) : req_i.num;
      rem_q <= '0;
      den_q <= req_i.den;
    end else if (busy_q) begin
      sh_q  <= {sh_q[bbe_pkg::NW-2:0], ge};
      rem_q <= rem_nx[bbe_pkg::DW-1:0];
    end else if (fin_q) begin
      // floor: a negative quotient with a remainder rounds away from zero
      quo_q <= neg_q ? (bbe_pkg::QW'(0) - ({1'b0, sh_q} + bbe_pkg::QW'(rem_q != '0)))
                     : {1'b0, sh_q};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
endmodule
`default_nettype wire

// ===== rtl/core/bspline_basis_evaluator_top.sv =====
// Top level: command sequencer around the knot RAM, basis RAM and divider.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+--------------------------------------
//  command   | start / busy               | cmd_i, knot_index_i, data_value_i
//  config    | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//  result    | result_valid_o (strobe)    | point_index_o, coefficient_o, last_o
//
// A load writes one knot. A generate writes count+degree+1 knots, one divider
// pass each unless rmin equals rmax. An evaluate searches the knots, then runs
// at most degree*(degree+3)/2 recursion elements on the shared serial divider.
// Results then come out one per cycle, count beats, through the basis RAM read
// register and the result register. No clearing pass after reset: RAM entries
// outside the live window read as zero. Results cannot be stalled; busy holds
// off commands.
`default_nettype none
module bspline_basis_evaluator_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [5:0]  knot_index_i,
  input  wire logic signed [31:0] data_value_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  output logic             result_valid_o,
  output logic [4:0]       point_index_o,
  output logic [16:0]      coefficient_o,
  output logic             last_o
);
  localparam int CP_W  = bbe_pkg::CP_W;
  localparam int CNT_W = bbe_pkg::CNT_W;
  localparam int DEG_W = bbe_pkg::DEG_W;
  localparam int DD_W  = bbe_pkg::DD_W;
  localparam int KA_W  = bbe_pkg::KA_W;
  localparam int KX_W  = bbe_pkg::KX_W;
  localparam int GP_W  = bbe_pkg::GP_W;
  localparam int NW    = bbe_pkg::NW;
  localparam int DW    = bbe_pkg::DW;
  localparam int QW    = bbe_pkg::QW;

  typedef enum logic [3:0] {
    S_IDLE, S_GEN_MUL, S_GEN_PREP, S_GEN_WAIT, S_GEN_WR,
    S_SRCH_RD, S_SRCH_CMP, S_SEED, S_FETCH, S_MUL, S_PREP, S_WAIT, S_WRITE, S_EMIT
  } state_e;

  state_e state_q;

  // configuration
  logic [DEG_W-1:0]   deg_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               mode_q;
  logic signed [31:0] rmin_q, rmax_q;

  // evaluate context
  logic signed [31:0] x_q;
  logic [CNT_W-1:0]   n_q, e_q;
  logic [DEG_W-1:0]   d_q;
  logic [CP_W-1:0]    k_q, i_q, lo_q, hi_q, seed_q;
  logic [DD_W-1:0]    dd_q;
  logic [2:0]         t_q;
  logic               ph_q, rec_q;
  logic signed [31:0] ki_q, kid_q, ki1_q, kid1_q;
  logic [16:0]        bi_q, bi1_q;
  logic               koob_q;
  logic signed [QW-1:0] a_q, b_q;
  logic signed [51:0] prod_q;
  logic [33:0]        tden_q;
  logic               tzero_q;

  // generate context
  logic [KX_W-1:0]    gk_q;
  logic [CNT_W-1:0]   gden_q;
  logic signed [32:0] grange_q;
  logic               gzero_q;
  logic signed [GP_W-1:0] gprod_q;

  // emit pipeline
  logic               pend_v_q, pend_last_q;
  logic [CP_W-1:0]    pend_idx_q;

  // RAM and divider hookup
  logic               kn_we, bs_we;
  logic [KA_W-1:0]    kn_wa;
  logic [31:0]        kn_wd, kn_rd;
  logic [KX_W-1:0]    kn_ra_x;
  logic               kn_oob;
  logic [CP_W-1:0]    bs_wa, bs_ra;
  logic [16:0]        bs_wd, bs_rd;
  bbe_pkg::div_req_t  div_req;
  bbe_pkg::div_rsp_t  div_rsp;

  logic               accept;
  logic signed [31:0] kval;
  logic [CNT_W-1:0]   ev_n;
  logic [DEG_W-1:0]   ev_dc, ev_d;
  logic               gen_ok;

  // term operands
  logic               tuse;
  logic signed [32:0] tnum, tden;
  logic [16:0]        tc;
  logic signed [33:0] tnum_f, tden_f;
  logic signed [51:0] tprod;
  logic signed [QW:0] tsum;
  logic [16:0]        tclamp;

  logic signed [KX_W:0] gks, degs, gj;
  logic signed [31:0] gval;

  logic [CP_W-1:0]    lo_nx, i_nx;
  logic [DD_W:0]      dd_inc;

  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // evaluation sizes: count into [1, MAX_CP], degree into [0, count-1]
  always_comb begin
    if (cnt_q == '0) ev_n = CNT_W'(1);
    else if (cnt_q > CNT_W'(bbe_pkg::MAX_CP)) ev_n = CNT_W'(bbe_pkg::MAX_CP);
    else ev_n = cnt_q;
    ev_dc = (deg_q > DEG_W'(bbe_pkg::MAX_DEG)) ? DEG_W'(bbe_pkg::MAX_DEG) : deg_q;
    ev_d  = (CNT_W'(ev_dc) > (ev_n - 1'b1)) ? DEG_W'(ev_n - 1'b1) : ev_dc;
    gen_ok = (cnt_q != '0) && (cnt_q > CNT_W'(deg_q)) &&
             (cnt_q <= CNT_W'(bbe_pkg::MAX_CP)) &&
             (deg_q <= DEG_W'(bbe_pkg::MAX_DEG));
  end

  // knot read address; indices at or past the table read as zero
  always_comb begin
    case (state_q)
      S_FETCH: begin
        case (t_q)
          3'd0:    kn_ra_x = KX_W'(i_q);
          3'd1:    kn_ra_x = KX_W'(i_q) + KX_W'(dd_q);
          3'd2:    kn_ra_x = KX_W'(i_q) + 1'b1;
          default: kn_ra_x = KX_W'(i_q) + KX_W'(dd_q) + 1'b1;
        endcase
      end
      S_SRCH_RD: kn_ra_x = KX_W'(k_q) + 1'b1;
      default:   kn_ra_x = '0;
    endcase
    kn_oob = kn_ra_x >= KX_W'(bbe_pkg::KNOT_DEPTH);
    kval   = koob_q ? 32'sd0 : $signed(kn_rd);
  end

  // generated knot: rmin + floor(range * j / (n - d)), saturated
  always_comb begin
    gks  = {1'b0, gk_q};
    degs = {{(KX_W + 1 - DEG_W){1'b0}}, deg_q};
    if (mode_q) gj = gks - degs;
    else if (gk_q <= KX_W'(deg_q)) gj = '0;
    else if (gk_q >= KX_W'(cnt_q)) gj = {{(KX_W + 1 - CNT_W){1'b0}}, gden_q};
    else gj = gks - degs;
    gval = gzero_q ? rmin_q
                   : bbe_pkg::sat32({{(QW + 1 - 32){rmin_q[31]}}, rmin_q} +
                                    {div_rsp.quo[QW-1], div_rsp.quo});
  end

  // recursion term operands; phase 0 is the left term, phase 1 the right one
  always_comb begin
    if (!ph_q) begin
      tuse = (KX_W'(i_q) + KX_W'(dd_q)) > KX_W'(k_q);
      tnum = {x_q[31], x_q} - {ki_q[31], ki_q};
      tden = {kid_q[31], kid_q} - {ki_q[31], ki_q};
      tc   = bi_q;
    end else begin
      tuse = i_q < k_q;
      tnum = {kid1_q[31], kid1_q} - {x_q[31], x_q};
      tden = {kid1_q[31], kid1_q} - {ki1_q[31], ki1_q};
      tc   = bi1_q;
    end
    tnum_f = tden[32] ? (34'sd0 - {tnum[32], tnum}) : {tnum[32], tnum};
    tden_f = tden[32] ? (34'sd0 - {tden[32], tden}) : {tden[32], tden};
    tprod  = tnum_f * $signed({1'b0, tc});
    tsum   = {a_q[QW-1], a_q} + {b_q[QW-1], b_q};
    tclamp = bbe_pkg::clampq(tsum);
  end

  // window bounds: max(0, k - dd) and max(0, k - dd - 1)
  always_comb begin
    dd_inc = {1'b0, dd_q} + 1'b1;
    lo_nx  = (KX_W'(k_q) > KX_W'(dd_q)) ? (k_q - CP_W'(dd_q)) : '0;
    i_nx   = (KX_W'(k_q) > KX_W'(dd_inc)) ? (k_q - CP_W'(dd_inc)) : '0;
  end

  // RAM ports and divider request
  always_comb begin
    kn_we = 1'b0;
    kn_wa = knot_index_i[KA_W-1:0];
    kn_wd = data_value_i;
    if (state_q == S_IDLE) begin
      kn_we = accept && (cmd_i == bbe_pkg::CMD_LOAD) &&
              (knot_index_i < 6'(bbe_pkg::KNOT_DEPTH));
    end else if (state_q == S_GEN_WR) begin
      kn_we = 1'b1;
      kn_wa = gk_q[KA_W-1:0];
      kn_wd = gval;
    end

    bs_we = (state_q == S_SEED) || (state_q == S_WRITE);
    bs_wa = (state_q == S_SEED) ? seed_q : i_q;
    bs_wd = (state_q == S_SEED) ? bbe_pkg::Q_ONE : tclamp;
    if (state_q == S_EMIT) bs_ra = e_q[CP_W-1:0];
    else if (state_q == S_FETCH && t_q == 3'd1) bs_ra = i_q + 1'b1;
    else bs_ra = i_q;

    div_req.start = 1'b0;
    div_req.num   = {{(NW - 53){prod_q[51]}}, prod_q, 1'b0} + NW'(tden_q);
    div_req.den   = DW'({tden_q, 1'b0});
    if (state_q == S_PREP) begin
      div_req.start = !tzero_q;
    end else if (state_q == S_GEN_PREP) begin
      div_req.start = 1'b1;
      div_req.num   = {{(NW - GP_W){gprod_q[GP_W-1]}}, gprod_q};
      div_req.den   = DW'(gden_q);
    end
  end

  bbe_ram #(.Width(32), .Depth(bbe_pkg::KNOT_DEPTH)) u_knot_ram (
    .clk_i   (clk_i),
    .we_i    (kn_we),
    .waddr_i (kn_wa),
    .wdata_i (kn_wd),
    .raddr_i (kn_ra_x[KA_W-1:0]),
    .rdata_o (kn_rd)
  );

  bbe_ram #(.Width(17), .Depth(bbe_pkg::MAX_CP)) u_basis_ram (
    .clk_i   (clk_i),
    .we_i    (bs_we),
    .waddr_i (bs_wa),
    .wdata_i (bs_wd),
    .raddr_i (bs_ra),
    .rdata_o (bs_rd)
  );

  bbe_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      deg_q    <= DEG_W'(3);
      cnt_q    <= CNT_W'(8);
      mode_q   <= 1'b0;
      rmin_q   <= 32'sd0;
      rmax_q   <= 32'sd65536;
      x_q      <= '0;
      n_q      <= '0;
      e_q      <= '0;
      d_q      <= '0;
      k_q      <= '0;
      i_q      <= '0;
      lo_q     <= '0;
      hi_q     <= '0;
      seed_q   <= '0;
      dd_q     <= '0;
      t_q      <= '0;
      ph_q     <= 1'b0;
      rec_q    <= 1'b0;
      ki_q     <= '0;
      kid_q    <= '0;
      ki1_q    <= '0;
      kid1_q   <= '0;
      bi_q     <= '0;
      bi1_q    <= '0;
      koob_q   <= 1'b0;
      a_q      <= '0;
      b_q      <= '0;
      prod_q   <= '0;
      tden_q   <= '0;
      tzero_q  <= 1'b0;
      gk_q     <= '0;
      gden_q   <= '0;
      grange_q <= '0;
      gzero_q  <= 1'b0;
      gprod_q  <= '0;
      pend_v_q    <= 1'b0;
      pend_last_q <= 1'b0;
      pend_idx_q  <= '0;
      result_valid_o <= 1'b0;
      point_index_o  <= '0;
      coefficient_o  <= '0;
      last_o         <= 1'b0;
    end else begin
      koob_q   <= kn_oob;
      pend_v_q <= (state_q == S_EMIT) && (e_q < n_q);

      // config beats
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          bbe_pkg::REG_DEGREE: deg_q  <= cfg_data_i[DEG_W-1:0];
          bbe_pkg::REG_COUNT:  cnt_q  <= cfg_data_i[CNT_W-1:0];
          bbe_pkg::REG_MODE:   mode_q <= cfg_data_i[0];
          bbe_pkg::REG_RMIN:   rmin_q <= cfg_data_i;
          bbe_pkg::REG_RMAX:   rmax_q <= cfg_data_i;
          default: ;
        endcase
      end

      // result stage: entries outside the live window read as zero
      result_valid_o <= pend_v_q;
      point_index_o  <= pend_idx_q;
      last_o         <= pend_v_q && pend_last_q;
      coefficient_o  <= (pend_idx_q >= lo_q && pend_idx_q <= hi_q) ? bs_rd : '0;

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            unique case (cmd_i)
              bbe_pkg::CMD_GEN: begin
                if (gen_ok) begin
                  gk_q     <= '0;
                  gden_q   <= cnt_q - CNT_W'(deg_q);
                  grange_q <= {rmax_q[31], rmax_q} - {rmin_q[31], rmin_q};
                  gzero_q  <= (rmax_q == rmin_q);
                  state_q  <= S_GEN_MUL;
                end
              end
              bbe_pkg::CMD_EVAL: begin
                x_q <= data_value_i;
                n_q <= ev_n;
                d_q <= ev_d;
                k_q <= '0;
                if (data_value_i <= rmin_q) begin
                  seed_q  <= '0;
                  rec_q   <= 1'b0;
                  state_q <= S_SEED;
                end else if (data_value_i >= rmax_q) begin
                  seed_q  <= CP_W'(ev_n - 1'b1);
                  rec_q   <= 1'b0;
                  state_q <= S_SEED;
                end else begin
                  rec_q   <= 1'b1;
                  state_q <= S_SRCH_RD;
                end
              end
              default: ;
            endcase
          end
        end

        S_GEN_MUL: begin
          gprod_q <= grange_q * gj;
          state_q <= gzero_q ? S_GEN_WR : S_GEN_PREP;
        end

        S_GEN_PREP: state_q <= S_GEN_WAIT;

        S_GEN_WAIT: begin
          if (div_rsp.done) state_q <= S_GEN_WR;
        end

        S_GEN_WR: begin
          if (gk_q == (KX_W'(cnt_q) + KX_W'(deg_q)) ||
              gk_q == KX_W'(bbe_pkg::KNOT_DEPTH - 1)) begin
            state_q <= S_IDLE;
          end else begin
            gk_q    <= gk_q + 1'b1;
            state_q <= S_GEN_MUL;
          end
        end

        // interval search: first k with x < knot[k+1], at most n-1
        S_SRCH_RD: begin
          if (CNT_W'(k_q) == (n_q - 1'b1)) begin
            seed_q  <= k_q;
            state_q <= S_SEED;
          end else begin
            state_q <= S_SRCH_CMP;
          end
        end

        S_SRCH_CMP: begin
          if (x_q < kval) begin
            seed_q  <= k_q;
            state_q <= S_SEED;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= S_SRCH_RD;
          end
        end

        S_SEED: begin
          lo_q <= seed_q;
          hi_q <= seed_q;
          k_q  <= seed_q;
          e_q  <= '0;
          if (rec_q && d_q != '0) begin
            dd_q    <= DD_W'(1);
            i_q     <= (seed_q != '0) ? (seed_q - 1'b1) : '0;
            t_q     <= '0;
            ph_q    <= 1'b0;
            state_q <= S_FETCH;
          end else begin
            state_q <= S_EMIT;
          end
        end

        // four knots and two old coefficients, one read each per cycle
        S_FETCH: begin
          t_q <= (t_q == 3'd4) ? 3'd0 : (t_q + 1'b1);
          case (t_q)
            3'd1: begin
              ki_q <= kval;
              bi_q <= bs_rd;
            end
            3'd2: begin
              kid_q <= kval;
              bi1_q <= bs_rd;
            end
            3'd3: ki1_q <= kval;
            3'd4: begin
              kid1_q  <= kval;
              ph_q    <= 1'b0;
              state_q <= S_MUL;
            end
            default: ;
          endcase
        end

        S_MUL: begin
          tzero_q <= !tuse || (tden == 33'sd0);
          prod_q  <= tprod;
          tden_q  <= tden_f[33:0];
          state_q <= S_PREP;
        end

        S_PREP: begin
          if (tzero_q) begin
            if (!ph_q) begin
              a_q     <= '0;
              ph_q    <= 1'b1;
              state_q <= S_MUL;
            end else begin
              b_q     <= '0;
              state_q <= S_WRITE;
            end
          end else begin
            state_q <= S_WAIT;
          end
        end

        S_WAIT: begin
          if (div_rsp.done) begin
            if (!ph_q) begin
              a_q     <= div_rsp.quo;
              ph_q    <= 1'b1;
              state_q <= S_MUL;
            end else begin
              b_q     <= div_rsp.quo;
              state_q <= S_WRITE;
            end
          end
        end

        S_WRITE: begin
          ph_q <= 1'b0;
          t_q  <= '0;
          if (i_q == k_q) begin
            lo_q <= lo_nx;
            if (DD_W'(d_q) == dd_q) begin
              state_q <= S_EMIT;
            end else begin
              dd_q    <= dd_inc[DD_W-1:0];
              i_q     <= i_nx;
              state_q <= S_FETCH;
            end
          end else begin
            i_q     <= i_q + 1'b1;
            state_q <= S_FETCH;
          end
        end

        S_EMIT: begin
          if (e_q < n_q) begin
            pend_idx_q  <= e_q[CP_W-1:0];
            pend_last_q <= (e_q == (n_q - 1'b1));
            e_q         <= e_q + 1'b1;
          end else begin
            state_q <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/bbe_checker.sv =====
// Port-level checker for the B-spline basis evaluator, bound to the top.
`default_nettype none
`include "assert_macros.svh"
module bbe_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        result_valid_o,
  input wire logic [4:0]  point_index_o,
  input wire logic [16:0] coefficient_o,
  input wire logic        last_o
);
  `BBE_ASSERT_IMP(a_last_valid, last_o, result_valid_o, "last without a result beat")
  `BBE_ASSERT_IMP(a_coef_range, result_valid_o, coefficient_o <= 17'h10000, "coef above one")
  `BBE_ASSERT_NXT(a_idx_step, result_valid_o && !last_o, result_valid_o && (point_index_o == ($past(point_index_o) + 5'd1)), "result beats not consecutive")
  `BBE_ASSERT_IMP(a_res_busy, result_valid_o, busy || $past(busy) || $past(busy, 2), "result beat outside a command")
endmodule

bind bspline_basis_evaluator_top bbe_checker u_bbe_checker (.*);
`default_nettype wire
